// ----- rtl/core/i2cbm_pkg.sv -----
// ----------------------------------------------------------------------------
// I2C bus monitor package
// Shared types and constants for the bus monitor decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cbm_pkg;

    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_STOP  = 2'd1;
    localparam logic [1:0] KIND_DATA  = 2'd2;
    localparam logic [1:0] KIND_ACK   = 2'd3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // One queue entry: an event, or a marker that closes the previous event's word
    typedef struct packed {
        logic       marker;
        logic [1:0] kind;
        logic [7:0] value;
        logic       last;
    } t_entry;

endpackage

`default_nettype wire

// ----- rtl/core/i2c_bus_monitor_decoder_top.sv -----
// ----------------------------------------------------------------------------
// I2C bus monitor decoder
// Decodes START, STOP, data bytes and acknowledge bits from packed samples.
// ----------------------------------------------------------------------------
//  channel | handshake         | payload
//  --------+-------------------+-------------------------------------------
//  input   | i_push / o_full   | i_packed_word
//  result  | o_empty / i_pop   | o_event_kind, o_event_data, o_last_of_word
//
//  One sample per cycle, stalls aside: a word's SAMPLES_PER_WORD samples pass
//  the front end, and the next word is accepted in the cycle its last sample
//  is taken. An event that ends its word goes via the queue, stage and result
//  registers to the port; others wait for the word's next event or end marker.
//  Synchronous active-low reset clears all control state; no clearing pass.
//  A full queue stalls the walk only on samples that push an event or a marker.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_bus_monitor_decoder_top #(
    parameter int SAMPLES_PER_WORD = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_push,
    output logic        o_full,
    input  wire  [31:0] i_packed_word,
    output logic        o_empty,
    input  wire         i_pop,
    output logic [1:0]  o_event_kind,
    output logic [7:0]  o_event_data,
    output logic        o_last_of_word
);
    import i2cbm_pkg::*;

    logic   q_push;
    t_entry q_in;
    logic   q_full;
    logic   q_pop;
    t_entry q_out;
    logic   q_empty;

    i2cbm_front #(
        .SAMPLES_PER_WORD(SAMPLES_PER_WORD)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .o_full       (o_full),
        .i_packed_word(i_packed_word),
        .o_q_push     (q_push),
        .o_q_entry    (q_in),
        .i_q_full     (q_full)
    );

    i2cbm_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_data (q_in),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_data (q_out),
        .o_empty(q_empty)
    );

    i2cbm_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_data      (q_out),
        .i_q_empty     (q_empty),
        .o_q_pop       (q_pop),
        .o_empty       (o_empty),
        .i_pop         (i_pop),
        .o_event_kind  (o_event_kind),
        .o_event_data  (o_event_data),
        .o_last_of_word(o_last_of_word)
    );

endmodule

`default_nettype wire

// ----- rtl/core/i2cbm_front.sv -----
// ----------------------------------------------------------------------------
// I2C bus monitor front end
// Takes a word, walks its samples one per cycle unless stalled; finds events.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbm_front #(
    parameter int SAMPLES_PER_WORD = 16
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_push,
    output logic                  o_full,
    input  wire  [31:0]           i_packed_word,
    output logic                  o_q_push,
    output i2cbm_pkg::t_entry     o_q_entry,
    input  wire                   i_q_full
);
    import i2cbm_pkg::*;

    localparam int LW = $clog2(SAMPLES_PER_WORD + 1);

    typedef enum logic [1:0] {
        PEND_NONE  = 2'd0,
        PEND_START = 2'd1,
        PEND_STOP  = 2'd2
    } t_pend;

    logic          r_busy;
    logic [31:0]   r_word;
    logic [LW-1:0] r_left;
    logic          r_open;
    logic          r_levels_seen;
    logic          r_last_sda;
    logic          r_last_scl;
    logic          r_in_tx;
    t_pend         r_pend;
    logic [3:0]    r_bits;
    logic [7:0]    r_shift;

    logic          n_in_tx;
    t_pend         n_pend;
    logic [3:0]    n_bits;
    logic [7:0]    n_shift;
    logic          ev;
    logic [1:0]    ev_kind;
    logic [7:0]    ev_value;
    logic          sda;
    logic          scl;
    logic          final_smp;
    logic          need_push;
    logic          advance;
    logic          accept;

    assign sda       = r_word[30];
    assign scl       = r_word[31];
    assign final_smp = (r_left == LW'(1));

    always_comb begin
        n_in_tx  = r_in_tx;
        n_pend   = r_pend;
        n_bits   = r_bits;
        n_shift  = r_shift;
        ev       = 1'b0;
        ev_kind  = KIND_START;
        ev_value = 8'd0;
        if (r_levels_seen) begin
            if (r_pend != PEND_NONE) begin
                if (scl) begin
                    if (r_pend == PEND_START && !sda) begin
                        n_in_tx = 1'b1;
                        n_bits  = 4'd0;
                        n_shift = 8'd0;
                        ev      = 1'b1;
                        ev_kind = KIND_START;
                    end else if (r_pend == PEND_STOP && sda) begin
                        n_in_tx = 1'b0;
                        n_bits  = 4'd0;
                        n_shift = 8'd0;
                        ev      = 1'b1;
                        ev_kind = KIND_STOP;
                    end
                end
                n_pend = PEND_NONE;
            end else if (r_last_scl && scl) begin
                if (r_last_sda && !sda) begin
                    n_pend = PEND_START;
                end else if (!r_last_sda && sda) begin
                    n_pend = PEND_STOP;
                end
            end
            // a confirming sample never has an SCL rising edge
            if (!r_last_scl && scl && n_in_tx) begin
                if (r_bits < 4'd8) begin
                    n_shift = {r_shift[6:0], sda};
                    n_bits  = r_bits + 4'd1;
                    if (r_bits == 4'd7) begin
                        ev       = 1'b1;
                        ev_kind  = KIND_DATA;
                        ev_value = {r_shift[6:0], sda};
                    end
                end else begin
                    ev       = 1'b1;
                    ev_kind  = KIND_ACK;
                    ev_value = {7'd0, sda};
                    n_bits   = 4'd0;
                    n_shift  = 8'd0;
                end
            end
        end
    end

    // marker closes a word that made an event but whose final sample made none
    assign need_push = ev || (final_smp && r_open);
    assign advance   = r_busy && !(need_push && i_q_full);
    assign o_full    = r_busy && !(advance && final_smp);
    assign accept    = i_push && !o_full;

    assign o_q_push         = advance && need_push;
    assign o_q_entry.marker = !ev;
    assign o_q_entry.kind   = ev_kind;
    assign o_q_entry.value  = ev_value;
    assign o_q_entry.last   = final_smp && ev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy        <= 1'b0;
            r_left        <= '0;
            r_open        <= 1'b0;
            r_levels_seen <= 1'b0;
            r_last_sda    <= 1'b0;
            r_last_scl    <= 1'b0;
            r_in_tx       <= 1'b0;
            r_pend        <= PEND_NONE;
            r_bits        <= 4'd0;
            r_shift       <= 8'd0;
        end else begin
            if (advance) begin
                r_levels_seen <= 1'b1;
                r_last_sda    <= sda;
                r_last_scl    <= scl;
                r_in_tx       <= n_in_tx;
                r_pend        <= n_pend;
                r_bits        <= n_bits;
                r_shift       <= n_shift;
                if (final_smp) begin
                    r_open <= 1'b0;
                end else if (ev) begin
                    r_open <= 1'b1;
                end
            end
            // a new word can only arrive while idle or on the final sample
            if (accept) begin
                r_busy <= 1'b1;
                r_word <= i_packed_word;
                r_left <= LW'(SAMPLES_PER_WORD);
            end else if (advance) begin
                r_word <= {r_word[29:0], 2'b00};
                r_left <= r_left - LW'(1);
                if (final_smp) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/i2cbm_fifo.sv -----
// ----------------------------------------------------------------------------
// I2C bus monitor event queue
// Short FIFO between event detection and result delivery.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbm_fifo (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push,
    input  i2cbm_pkg::t_entry  i_data,
    output logic               o_full,
    input  wire                i_pop,
    output i2cbm_pkg::t_entry  o_data,
    output logic               o_empty
);
    import i2cbm_pkg::*;

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr;
    logic [QUEUE_AW-1:0] r_rd;
    logic [QUEUE_AW:0]   r_count;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + QUEUE_AW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + QUEUE_AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (QUEUE_AW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (QUEUE_AW+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/i2cbm_back.sv -----
// ----------------------------------------------------------------------------
// I2C bus monitor back end
// Resolves the end-of-word flag and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbm_back (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  i2cbm_pkg::t_entry  i_q_data,
    input  wire                i_q_empty,
    output logic               o_q_pop,
    output logic               o_empty,
    input  wire                i_pop,
    output logic [1:0]         o_event_kind,
    output logic [7:0]         o_event_data,
    output logic               o_last_of_word
);
    import i2cbm_pkg::*;

    // stage holds an event until its last flag or next entry says if it ends its word
    t_entry r_stage;
    logic   r_stage_valid;
    logic   r_out_valid;
    logic   resolved;
    logic   out_free;
    logic   move;
    logic   head_marker;
    logic   eat_marker;
    logic   fill;

    assign resolved    = r_stage_valid && (r_stage.last || !i_q_empty);
    assign out_free    = !r_out_valid || i_pop;
    assign move        = resolved && out_free;
    assign head_marker = !i_q_empty && i_q_data.marker;
    assign eat_marker  = (move && !r_stage.last && head_marker) ||
                         (!r_stage_valid && head_marker);
    assign fill        = !i_q_empty && !i_q_data.marker && (!r_stage_valid || move);
    assign o_q_pop     = fill || eat_marker;
    assign o_empty     = !r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage_valid <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (fill) begin
                r_stage       <= i_q_data;
                r_stage_valid <= 1'b1;
            end else if (move) begin
                r_stage_valid <= 1'b0;
            end
            if (move) begin
                r_out_valid    <= 1'b1;
                o_event_kind   <= r_stage.kind;
                o_event_data   <= r_stage.value;
                o_last_of_word <= r_stage.last || head_marker;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/i2cbm_checker.sv -----
// ----------------------------------------------------------------------------
// I2C bus monitor checker
// Port-level checks on the decoder's result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbm_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_push,
    input wire        o_full,
    input wire [31:0] i_packed_word,
    input wire        o_empty,
    input wire        i_pop,
    input wire [1:0]  o_event_kind,
    input wire [7:0]  o_event_data,
    input wire        o_last_of_word
);
    import i2cbm_pkg::*;

    logic unused_in;
    assign unused_in = i_push ^ o_full ^ (^i_packed_word) ^ o_last_of_word;

    a_reset_empty: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> o_empty)
        else $error("result pending right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_event_kind) &&
                                  $stable(o_event_data) && $stable(o_last_of_word)))
        else $error("stalled item changed");

    a_cond_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && (o_event_kind == KIND_START || o_event_kind == KIND_STOP))
        |-> (o_event_data == 8'd0))
        else $error("start/stop item with nonzero value");

    a_ack_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_event_kind == KIND_ACK) |-> (o_event_data[7:1] == 7'd0))
        else $error("ack item wider than one bit");

endmodule

bind i2c_bus_monitor_decoder_top i2cbm_checker u_checker (.*);

`default_nettype wire

// ----- bench/i2c_bus_monitor_decoder_top_tb.sv -----
// ----------------------------------------------------------------------------
// I2C bus monitor decoder testbench
// Drives packed SDA/SCL sample words and predicts the START, STOP, data byte
// and acknowledge events they cause. Every event popped from the block is
// checked against the oldest predicted event. Both handshakes stall at random
// and the receiver stops popping for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module i2c_bus_monitor_decoder_top_tb;

    import i2cbm_pkg::*;

    typedef struct {
        logic [1:0] kind;
        logic [7:0] value;
        logic       last;
    } t_bus_event;

    typedef enum logic [1:0] {
        COND_NONE  = 2'd0,
        COND_START = 2'd1,
        COND_STOP  = 2'd2
    } t_cond;

    localparam int SAMPLES = 16;

    // Bus decoder model plus the list of events still owed by the block
    class i2c_event_scoreboard;
        logic       levels_seen;
        logic       prev_sda;
        logic       prev_scl;
        logic       in_xfer;
        t_cond      cond;
        logic [3:0] bits_taken;
        logic [7:0] shift_reg;
        t_bus_event word_events[$];
        t_bus_event pending_events[$];
        int         errors;

        function new();
            levels_seen = 1'b0;
            prev_sda    = 1'b0;
            prev_scl    = 1'b0;
            in_xfer     = 1'b0;
            cond        = COND_NONE;
            bits_taken  = 4'd0;
            shift_reg   = 8'h00;
            errors      = 0;
        endfunction

        function void emit(logic [1:0] kind, logic [7:0] value);
            t_bus_event ev;
            ev.kind  = kind;
            ev.value = value;
            ev.last  = 1'b0;
            word_events.push_back(ev);
        endfunction

        // Walk the 16 samples of an accepted word, top pair first
        function void note_word(logic [31:0] w);
            logic       sda;
            logic       scl;
            logic       confirming;
            t_bus_event ev;
            word_events.delete();
            for (int i = 0; i < SAMPLES; i++) begin
                sda = w[31 - 2 * i - 1];
                scl = w[31 - 2 * i];
                confirming = 1'b0;
                if (!levels_seen) begin
                    levels_seen = 1'b1;
                    prev_sda    = sda;
                    prev_scl    = scl;
                    continue;
                end
                if (cond != COND_NONE) begin
                    confirming = 1'b1;
                    if (scl) begin
                        if (cond == COND_START && !sda) begin
                            in_xfer    = 1'b1;
                            bits_taken = 4'd0;
                            shift_reg  = 8'h00;
                            emit(KIND_START, 8'h00);
                        end else if (cond == COND_STOP && sda) begin
                            in_xfer    = 1'b0;
                            bits_taken = 4'd0;
                            shift_reg  = 8'h00;
                            emit(KIND_STOP, 8'h00);
                        end
                    end
                    cond = COND_NONE;
                end
                if (!confirming && prev_scl && scl) begin
                    if (prev_sda && !sda)
                        cond = COND_START;
                    else if (!prev_sda && sda)
                        cond = COND_STOP;
                end
                if (!prev_scl && scl && in_xfer) begin
                    if (bits_taken < 4'd8) begin
                        shift_reg  = {shift_reg[6:0], sda};
                        bits_taken = bits_taken + 4'd1;
                        if (bits_taken == 4'd8)
                            emit(KIND_DATA, shift_reg);
                    end else begin
                        emit(KIND_ACK, {7'd0, sda});
                        bits_taken = 4'd0;
                        shift_reg  = 8'h00;
                    end
                end
                prev_sda = sda;
                prev_scl = scl;
            end
            if (word_events.size() > 0) begin
                ev = word_events.pop_back();
                ev.last = 1'b1;
                word_events.push_back(ev);
            end
            foreach (word_events[k])
                pending_events.push_back(word_events[k]);
        endfunction

        task report_mismatch(string what);
            $display("mismatch at %0t: %s", $time, what);
            errors++;
        endtask

        task check_event(logic [1:0] kind, logic [7:0] value, logic last);
            t_bus_event exp_ev;
            if (pending_events.size() == 0) begin
                report_mismatch($sformatf("unexpected event kind %0d value %02h last %0d",
                                          kind, value, last));
                return;
            end
            exp_ev = pending_events.pop_front();
            if (kind !== exp_ev.kind)
                report_mismatch($sformatf("event_kind %0d, want %0d", kind, exp_ev.kind));
            if (value !== exp_ev.value)
                report_mismatch($sformatf("event_data %02h, want %02h", value, exp_ev.value));
            if (last !== exp_ev.last)
                report_mismatch($sformatf("last_of_word %0d, want %0d", last, exp_ev.last));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_push = 1'b0;
    logic [31:0] i_packed_word = 32'h0000_0000;
    logic        i_pop = 1'b0;
    logic        o_full;
    logic        o_empty;
    logic [1:0]  o_event_kind;
    logic [7:0]  o_event_data;
    logic        o_last_of_word;

    i2c_event_scoreboard sb;

    int          sent_words = 0;
    int          cycle_count = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    bit          fast_timing = 1'b1;
    logic [31:0] sample_word = 32'h0000_0000;
    int          sample_count = 0;

    i2c_bus_monitor_decoder_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_packed_word  (i_packed_word),
        .o_empty        (o_empty),
        .i_pop          (i_pop),
        .o_event_kind   (o_event_kind),
        .o_event_data   (o_event_data),
        .o_last_of_word (o_last_of_word)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Result side: random pops, a stretch of steady pops, one long hold-off once traffic is flowing
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else begin
            if (i_pop && !o_empty)
                sb.check_event(o_event_kind, o_event_data, o_last_of_word);
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                i_pop <= 1'b0;
            end else if (!hold_done && sent_words >= 30) begin
                hold_done = 1'b1;
                hold_left = 299;
                i_pop <= 1'b0;
            end else if (cycle_count >= 1500 && cycle_count < 2500) begin
                i_pop <= 1'b1;
            end else begin
                i_pop <= ($urandom_range(99) >= 23);
            end
        end
    end

    task automatic send_word(input logic [31:0] w);
        while (!(sent_words >= 60 && sent_words < 85) && $urandom_range(99) < 23) begin
            i_push <= 1'b0;
            @(posedge i_clk);
        end
        i_push        <= 1'b1;
        i_packed_word <= w;
        do @(posedge i_clk); while (o_full);
        sb.note_word(w);
        sent_words++;
    endtask

    function automatic int reps(input int max_reps);
        return fast_timing ? 1 : $urandom_range(max_reps, 1);
    endfunction

    // Append samples to the word being built; full words go out on the bus
    task automatic put_sample(input logic sda, input logic scl, input int count);
        repeat (count) begin
            sample_word = {sample_word[29:0], scl, sda};
            sample_count++;
            if (sample_count == SAMPLES) begin
                send_word(sample_word);
                sample_count = 0;
            end
        end
    endtask

    task automatic flush_samples();
        while (sample_count != 0)
            put_sample(1'b1, 1'b1, 1);
    endtask

    // Works from idle and as a repeated start after a byte's acknowledge bit
    task automatic send_start();
        put_sample(1'b1, 1'b0, 1);
        put_sample(1'b1, 1'b1, reps(2));
        put_sample(1'b0, 1'b1, reps(2) + 1);
        put_sample(1'b0, 1'b0, reps(2));
    endtask

    task automatic send_stop();
        put_sample(1'b0, 1'b0, 1);
        put_sample(1'b0, 1'b1, reps(2));
        put_sample(1'b1, 1'b1, reps(2) + 1);
    endtask

    task automatic send_bit(input logic b);
        put_sample(b, 1'b0, reps(2));
        put_sample(b, 1'b1, reps(3));
        put_sample(b, 1'b0, reps(2));
    endtask

    task automatic send_byte(input logic [7:0] data, input logic nack);
        for (int i = 7; i >= 0; i--)
            send_bit(data[i]);
        send_bit(nack);
    endtask

    // One transfer with random bytes; a broken one aborts or glitches mid-byte
    task automatic send_transfer(input bit broken);
        int   n_bytes;
        int   bad_byte;
        int   bad_bit;
        bit   glitch;
        logic [7:0] data;
        logic b;
        n_bytes  = $urandom_range(4, 1);
        bad_byte = $urandom_range(n_bytes - 1, 0);
        bad_bit  = $urandom_range(8, 0);
        glitch   = 1'($urandom_range(1, 0));
        put_sample(1'b1, 1'b1, reps(4));
        send_start();
        for (int j = 0; j < n_bytes; j++) begin
            data = 8'($urandom_range(255, 0));
            if ($urandom_range(5, 0) == 0 && j > 0)
                send_start();
            for (int i = 8; i >= 0; i--) begin
                b = (i == 0) ? ($urandom_range(3, 0) == 0) : data[i - 1];
                if (broken && j == bad_byte && 8 - i == bad_bit) begin
                    if (!glitch) begin
                        send_stop();
                        return;
                    end
                    // short SDA pulse while SCL is high
                    put_sample(b, 1'b0, reps(2));
                    put_sample(b, 1'b1, reps(2));
                    put_sample(~b, 1'b1, 1);
                    put_sample(b, 1'b1, reps(2));
                    put_sample(b, 1'b0, reps(2));
                end else begin
                    send_bit(b);
                end
            end
        end
        send_stop();
    endtask

    initial begin
        int pick;
        sb = new();
        i_rst_n <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // first word only seeds levels; then flat and toggling buses
        send_word(32'h0000_0000);
        send_word(32'hFFFF_FFFF);
        send_word(32'h3333_3333);
        send_word(32'hAAAA_AAAA);
        send_word(32'h5555_5555);
        put_sample(1'b1, 1'b1, 2);
        // start dropped because SDA goes back high
        put_sample(1'b0, 1'b1, 1);
        put_sample(1'b1, 1'b1, 2);
        // start dropped because SCL falls on the confirming sample
        put_sample(1'b0, 1'b1, 1);
        put_sample(1'b0, 1'b0, 1);
        put_sample(1'b1, 1'b0, 1);
        put_sample(1'b1, 1'b1, 1);
        // stop dropped, then a stop outside any transfer
        put_sample(1'b0, 1'b0, 1);
        put_sample(1'b0, 1'b1, 2);
        put_sample(1'b1, 1'b1, 1);
        put_sample(1'b0, 1'b1, 2);
        put_sample(1'b1, 1'b1, 2);
        send_start();
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hA5, 1'b0);
        send_start();
        send_byte(8'h5A, 1'b1);
        send_bit(1'b1);
        send_bit(1'b0);
        send_bit(1'b1);
        send_stop();
        send_start();
        send_byte(8'h81, 1'b0);
        send_stop();
        flush_samples();

        fast_timing = 1'b0;
        while (sent_words < 105) begin
            pick = $urandom_range(99, 0);
            if (pick < 70) begin
                send_transfer(1'b0);
            end else if (pick < 85) begin
                send_transfer(1'b1);
            end else begin
                repeat (SAMPLES)
                    put_sample(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)), 1);
            end
        end
        flush_samples();
        i_push <= 1'b0;

        while (sb.pending_events.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (sb.pending_events.size() != 0)
            sb.report_mismatch("events still expected at end of run");
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
